// File: hw/rtl/hpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpt_pkg;

    // Number format and fixed field widths
    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 32;
    localparam int IO_W        = 32;
    localparam int CFG_W       = 64;
    localparam int HALF_W      = CFG_W / 2;
    localparam int NUM_REGS    = 8;
    localparam int REG_IDX_W   = $clog2(NUM_REGS);
    localparam int NUM_ROWS    = 4;
    localparam int NUM_LANES   = 3;

    // Datapath widths
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int SUM_W  = 2 * COORD_WIDTH + 2;
    localparam int ROW_W  = SUM_W - FRAC_BITS;
    localparam int MAG_W  = ROW_W;
    localparam int QB     = COORD_WIDTH + 1;             // quotient bits, one extra for rounding
    localparam int NUM_W  = MAG_W + FRAC_BITS + 1;       // scaled dividend

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [ROW_W-1:0]       row_t;
    typedef logic [MAG_W-1:0]              mag_t;
    typedef logic [NUM_ROWS-1:0][NUM_ROWS-1:0][COORD_WIDTH-1:0] matrix_t;
    typedef logic [NUM_ROWS-1:0][ROW_W-1:0]                     rows_t;
    typedef logic [NUM_LANES-1:0][COORD_WIDTH-1:0]              vec3_t;

    typedef enum logic {
        OP_POINT  = 1'b0,
        OP_VECTOR = 1'b1
    } opcode_t;

    localparam logic [ROW_W-1:0] ROW_ONE =
        {{(ROW_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic [COORD_WIDTH-1:0] COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [COORD_WIDTH-1:0] val;
        logic                   ovf;
    } sat_t;

    // Per-item sideband carried alongside the dividers
    typedef struct packed {
        logic                                  use_alt;
        logic                                  wz;
        logic [NUM_LANES-1:0]                  neg;
        logic [NUM_LANES-1:0]                  alt_ovf;
        logic [NUM_LANES-1:0][COORD_WIDTH-1:0] alt;
    } side_t;

    typedef struct packed {
        logic [NUM_LANES-1:0][COORD_WIDTH-1:0] coord;
        logic                                  wz;
        logic                                  ovf;
    } res_t;

    // Clamp a row value to the coordinate range
    function automatic sat_t sat_row(input row_t v);
        sat_t r;
        logic [ROW_W-COORD_WIDTH:0] top;
        top   = v[ROW_W-1:COORD_WIDTH-1];
        r.ovf = !(&top) && (|top);
        if (r.ovf) begin
            r.val = v[ROW_W-1] ? COORD_MIN : COORD_MAX;
        end else begin
            r.val = v[COORD_WIDTH-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hpt_mac.sv
`timescale 1ns / 1ps
`default_nettype none

// Two stages: products, then rounded row sums
module hpt_mac (
    input  wire logic            aclk,
    input  wire logic            en,
    input  wire logic            op_in,
    input  wire hpt_pkg::vec3_t   coord_in,
    input  wire hpt_pkg::matrix_t mat,
    output hpt_pkg::rows_t        rows,
    output logic                 op_out
);
    import hpt_pkg::*;

    localparam logic [SUM_W-1:0] HALF = {{(SUM_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};

    logic signed [PROD_W-1:0]      prod_reg [NUM_ROWS][NUM_LANES];
    logic signed [COORD_WIDTH-1:0] t_reg    [NUM_ROWS];
    logic                          op1_reg;
    rows_t                         rows_reg;
    logic                          op2_reg;
    rows_t                         rows_next;

    // Stage 1: twelve products
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                for (int c = 0; c < NUM_LANES; c++) begin
                    prod_reg[r][c] <= $signed(mat[r][c]) * $signed(coord_in[c]);
                end
                t_reg[r] <= $signed(mat[r][NUM_ROWS-1]);
            end
            op1_reg <= op_in;
        end
    end

    // Stage 2: sum, translation in point mode, round half up
    always_comb begin
        logic signed [SUM_W-1:0] sum;
        for (int r = 0; r < NUM_ROWS; r++) begin
            sum = SUM_W'(prod_reg[r][0]) + SUM_W'(prod_reg[r][1]) + SUM_W'(prod_reg[r][2])
                + $signed(HALF);
            if (op1_reg == OP_POINT) begin
                sum = sum + (SUM_W'(t_reg[r]) <<< FRAC_BITS);
            end
            rows_next[r] = sum[SUM_W-1:FRAC_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rows_reg <= rows_next;
            op2_reg  <= op1_reg;
        end
    end

    assign rows   = rows_reg;
    assign op_out = op2_reg;

endmodule

`default_nettype wire

// File: hw/rtl/hpt_div_lane.sv
`timescale 1ns / 1ps
`default_nettype none

// Pipelined restoring divider: one quotient bit per stage
module hpt_div_lane (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire hpt_pkg::mag_t      num_mag,
    input  wire hpt_pkg::mag_t      den_mag,
    output logic [hpt_pkg::QB-1:0] quo,
    output logic                   ovf
);
    import hpt_pkg::*;

    logic [NUM_W-1:0] dividend;
    logic [MAG_W-1:0] rem_reg [QB];
    logic [MAG_W-1:0] den_reg [QB];
    logic [QB-1:0]    low_reg [QB];
    logic [QB-1:0]    quo_reg [QB];
    logic             ovf_reg [QB];

    logic [MAG_W-1:0] rem_in [QB];
    logic [MAG_W-1:0] den_in [QB];
    logic [QB-1:0]    low_in [QB];
    logic [QB-1:0]    quo_in [QB];
    logic             ovf_in [QB];

    assign dividend = {num_mag, {(FRAC_BITS+1){1'b0}}};

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [MAG_W:0]   trial;
        logic [MAG_W:0]   diff;
        logic             ge;

        if (k == 0) begin : g_first
            // quotient too large for the kept bits
            assign rem_in[k] = MAG_W'(dividend[NUM_W-1:QB]);
            assign den_in[k] = den_mag;
            assign low_in[k] = dividend[QB-1:0];
            assign quo_in[k] = '0;
            assign ovf_in[k] = (MAG_W'(dividend[NUM_W-1:QB]) >= den_mag);
        end else begin : g_next
            assign rem_in[k] = rem_reg[k-1];
            assign den_in[k] = den_reg[k-1];
            assign low_in[k] = low_reg[k-1];
            assign quo_in[k] = quo_reg[k-1];
            assign ovf_in[k] = ovf_reg[k-1];
        end

        assign trial = {rem_in[k], low_in[k][QB-1]};
        assign diff  = trial - {1'b0, den_in[k]};
        assign ge    = (trial >= {1'b0, den_in[k]});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                den_reg[k] <= den_in[k];
                low_reg[k] <= {low_in[k][QB-2:0], 1'b0};
                quo_reg[k] <= {quo_in[k][QB-2:0], ge};
                ovf_reg[k] <= ovf_in[k];
            end
        end
    end

    assign quo = quo_reg[QB-1];
    assign ovf = ovf_reg[QB-1];

endmodule

`default_nettype wire

// File: hw/rtl/homogeneous_point_transform.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake            Payload
// s_        s_valid / s_ready    s_opcode, s_in_x, s_in_y, s_in_z
// m_        m_valid / m_ready    m_out_x, m_out_y, m_out_z, m_w_zero, m_overflowed
// cfg_      cfg_wen (no wait)    cfg_index, cfg_wdata
//
// One item per cycle sustained unless an output stall fills the skid register.
// Stages from input transfer to m_valid: products, row sums, classify, 33 divider
// stages (one quotient bit each), output. The divider depth sets the latency.
// Synchronous active-low reset clears all valid bits and loads the identity
// matrix. On an output stall a skid register catches the last item, then s_ready
// drops and the whole pipeline holds.
module homogeneous_point_transform (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic                             s_opcode,
    input  wire logic [31:0]                      s_in_x,
    input  wire logic [31:0]                      s_in_y,
    input  wire logic [31:0]                      s_in_z,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic [31:0]                           m_out_x,
    output logic [31:0]                           m_out_y,
    output logic [31:0]                           m_out_z,
    output logic                                  m_w_zero,
    output logic                                  m_overflowed,
    input  wire logic                             cfg_wen,
    input  wire logic [hpt_pkg::REG_IDX_W-1:0]    cfg_index,
    input  wire logic [hpt_pkg::CFG_W-1:0]        cfg_wdata
);
    import hpt_pkg::*;

    localparam int DEPTH = 3 + QB;

    logic [CFG_W-1:0] cfg_reg [NUM_REGS];
    matrix_t          mat;
    vec3_t            coord_in;
    rows_t            rows;
    logic             op2;
    logic             en;
    logic [DEPTH-1:0] vld_reg;

    mag_t             un_reg [NUM_LANES];
    mag_t             ud_reg;
    side_t            side_reg [QB+1];
    side_t            side_next;
    logic [QB-1:0]    quo [NUM_LANES];
    logic             dovf [NUM_LANES];

    res_t             res_next;
    res_t             out_reg;
    res_t             skid_reg;
    logic             out_vld_reg;
    logic             skid_vld_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                cfg_reg[i] <= '0;
            end
            cfg_reg[0] <= CFG_W'(1) << FRAC_BITS;
            cfg_reg[2] <= CFG_W'(1) << (FRAC_BITS + HALF_W);
            cfg_reg[5] <= CFG_W'(1) << FRAC_BITS;
            cfg_reg[7] <= CFG_W'(1) << (FRAC_BITS + HALF_W);
        end else if (cfg_wen) begin
            cfg_reg[cfg_index] <= cfg_wdata;
        end
    end

    for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
        for (genvar c = 0; c < NUM_ROWS; c++) begin : g_col
            assign mat[r][c] = cfg_reg[r*2 + c/2][(c%2)*HALF_W +: COORD_WIDTH];
        end
    end

    assign coord_in[0] = s_in_x[COORD_WIDTH-1:0];
    assign coord_in[1] = s_in_y[COORD_WIDTH-1:0];
    assign coord_in[2] = s_in_z[COORD_WIDTH-1:0];

    // Pipeline advances unless the skid register is occupied
    assign en      = !skid_vld_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    hpt_mac u_mac (
        .aclk     (aclk),
        .en       (en),
        .op_in    (s_opcode),
        .coord_in (coord_in),
        .mat      (mat),
        .rows     (rows),
        .op_out   (op2)
    );

    // Classify: unit w, zero w, saturated bypass values, divider operands
    always_comb begin
        row_t w;
        row_t num;
        logic vec;
        logic w_one;
        logic w_zero;
        sat_t s;
        w      = rows[NUM_ROWS-1];
        vec    = (op2 == OP_VECTOR);
        w_one  = (rows[NUM_ROWS-1] == ROW_ONE);
        w_zero = (w == '0);
        side_next.use_alt = vec || w_one || w_zero;
        side_next.wz      = !vec && w_zero;
        for (int k = 0; k < NUM_LANES; k++) begin
            num = rows[k];
            side_next.neg[k] = num[ROW_W-1] ^ w[ROW_W-1];
            if (vec || w_one) begin
                s = sat_row(num);
            end else if (num == '0) begin
                s = '{val: '0, ovf: 1'b0};
            end else begin
                s = '{val: (num[ROW_W-1] ? COORD_MIN : COORD_MAX), ovf: 1'b1};
            end
            side_next.alt[k]     = s.val;
            side_next.alt_ovf[k] = s.ovf;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                un_reg[k] <= rows[k][ROW_W-1] ? MAG_W'(-rows[k]) : MAG_W'(rows[k]);
            end
            ud_reg <= rows[NUM_ROWS-1][ROW_W-1] ? MAG_W'(-rows[NUM_ROWS-1])
                                                : MAG_W'(rows[NUM_ROWS-1]);
            side_reg[0] <= side_next;
            for (int i = 1; i <= QB; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < NUM_LANES; k++) begin : g_lane
        hpt_div_lane u_div (
            .aclk    (aclk),
            .en      (en),
            .num_mag (un_reg[k]),
            .den_mag (ud_reg),
            .quo     (quo[k]),
            .ovf     (dovf[k])
        );
    end

    // Round, sign, saturate, merge with bypass path
    always_comb begin
        side_t            sd;
        logic [QB:0]      rnd;
        logic [QB-1:0]    qm;
        logic [NUM_LANES-1:0] lane_ovf;
        sd = side_reg[QB];
        for (int k = 0; k < NUM_LANES; k++) begin
            rnd = {1'b0, quo[k]} + (QB+1)'(1);
            qm  = rnd[QB:1];
            if (sd.use_alt) begin
                res_next.coord[k] = sd.alt[k];
                lane_ovf[k]       = sd.alt_ovf[k];
            end else if (sd.neg[k]) begin
                lane_ovf[k] = dovf[k] || (qm > QB'(COORD_MIN));
                res_next.coord[k] = lane_ovf[k] ? COORD_MIN : COORD_WIDTH'(-qm);
            end else begin
                lane_ovf[k] = dovf[k] || (qm > QB'(COORD_MAX));
                res_next.coord[k] = lane_ovf[k] ? COORD_MAX : qm[COORD_WIDTH-1:0];
            end
        end
        res_next.wz  = sd.wz;
        res_next.ovf = |lane_ovf;
    end

    // Output register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg  <= skid_vld_reg || (en && vld_reg[DEPTH-1]);
            skid_vld_reg <= 1'b0;
        end else if (en && vld_reg[DEPTH-1]) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_vld_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : res_next;
        end else if (en && vld_reg[DEPTH-1]) begin
            skid_reg <= res_next;
        end
    end

    assign m_valid      = out_vld_reg;
    assign m_out_x      = IO_W'($signed(out_reg.coord[0]));
    assign m_out_y      = IO_W'($signed(out_reg.coord[1]));
    assign m_out_z      = IO_W'($signed(out_reg.coord[2]));
    assign m_w_zero     = out_reg.wz;
    assign m_overflowed = out_reg.ovf;

endmodule

`default_nettype wire

// File: hw/rtl/hpt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module hpt_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_out_x,
    input wire logic [31:0] m_out_y,
    input wire logic [31:0] m_out_z,
    input wire logic        m_w_zero,
    input wire logic        m_overflowed
);

    // Result holds until transferred
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("m_valid dropped before transfer");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_out_x) && $stable(m_out_y) && $stable(m_out_z)
            && $stable(m_w_zero) && $stable(m_overflowed))
        else $error("result changed while stalled");

    // Zero w gives saturated or zero outputs only
    a_wzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_w_zero |-> m_overflowed
            || (m_out_x == 32'd0 && m_out_y == 32'd0 && m_out_z == 32'd0))
        else $error("zero w result neither saturated nor zero");

    // No result straight out of reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high after reset");

endmodule

bind homogeneous_point_transform hpt_checker u_hpt_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_out_x      (m_out_x),
    .m_out_y      (m_out_y),
    .m_out_z      (m_out_z),
    .m_w_zero     (m_w_zero),
    .m_overflowed (m_overflowed)
);

`default_nettype wire
